/* rtl/tsps_pkg.sv */
package tsps_pkg;

  // widths fixed by the register and beat formats
  localparam int MaxPhases = 4;
  localparam int DurW      = 16;
  localparam int PosW      = 20;
  localparam int CycW      = 18;
  localparam int IdxW      = 2;
  localparam int ModeW     = 3;
  localparam int CountW    = 3;
  localparam int WordW     = 19;
  localparam int ColorW    = 2;
  localparam int CfgIdxW   = 3;

  localparam logic [PosW-1:0] PosMax = '1;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegMode  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCount = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWord0 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWord1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWord2 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWord3 = 3'd5;

  // override modes that run the phase table
  localparam logic [ModeW-1:0] ModeSequence = 3'd0;
  localparam logic [ModeW-1:0] ModeSeqAlias = 3'd7;

  // lamp colors
  localparam logic [ColorW-1:0] ColorRed     = 2'd0;
  localparam logic [ColorW-1:0] ColorYellow  = 2'd1;
  localparam logic [ColorW-1:0] ColorGreen   = 2'd2;
  localparam logic [ColorW-1:0] ColorRedAlso = 2'd3;

  // phase word layout
  localparam int FlashBit = 18;
  localparam int ColorLsb = 16;

  // register reset values
  localparam logic [ModeW-1:0]  ModeReset  = 3'd0;
  localparam logic [CountW-1:0] CountReset = 3'd3;
  localparam logic [WordW-1:0]  Word0Reset = 19'd131112;
  localparam logic [WordW-1:0]  Word1Reset = 19'd65556;
  localparam logic [WordW-1:0]  Word2Reset = 19'd60;
  localparam logic [WordW-1:0]  Word3Reset = 19'd0;

  typedef struct packed {
    logic [DurW-1:0] elapsed_ticks;
    logic            first_event;
  } evt_t;

  typedef struct packed {
    logic            red_on;
    logic            yellow_on;
    logic            green_on;
    logic [IdxW-1:0] active_phase;
  } lamp_t;

  typedef struct packed {
    logic [ModeW-1:0]                   override_mode;
    logic [CountW-1:0]                  phase_count;
    logic [MaxPhases-1:0][WordW-1:0]    phase_word;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_WALK,
    ST_ADV,
    ST_WRAP,
    ST_DONE
  } seq_state_t;

endpackage

/* rtl/tsps_core.sv */
module tsps_core (
  input  logic               clk,
  input  logic               rst,
  input  tsps_pkg::cfg_t     cfg,
  input  logic               clear,
  input  logic               start,
  input  tsps_pkg::evt_t     evt,
  input  logic               take,
  output logic               idle,
  output logic               done,
  output tsps_pkg::lamp_t    result
);

  tsps_pkg::seq_state_t state, state_next;

  logic [tsps_pkg::PosW-1:0]   pos;
  logic [tsps_pkg::CycW-1:0]   cycle_len;
  logic [tsps_pkg::CycW-1:0]   thres;
  logic [tsps_pkg::IdxW-1:0]   idx;
  logic [tsps_pkg::IdxW-1:0]   phase;
  logic [tsps_pkg::DurW-1:0]   elapsed;
  logic                        first;

  logic [tsps_pkg::CountW-1:0] used;
  logic [tsps_pkg::IdxW-1:0]   last_idx;
  logic [tsps_pkg::DurW-1:0]   dur;
  logic                        seq_mode;

  logic [tsps_pkg::PosW-1:0]   op_a;
  logic [tsps_pkg::PosW-1:0]   op_b;
  logic                        op_sub;
  logic [tsps_pkg::PosW:0]     alu;
  logic [tsps_pkg::PosW-1:0]   alu_val;
  logic                        alu_carry;
  logic                        walk_hit;

  logic [tsps_pkg::WordW-1:0]  sel_word;
  logic [tsps_pkg::ModeW-1:0]  mode_m1;
  logic [tsps_pkg::ColorW-1:0] color;
  logic                        flash;
  logic                        dark;
  tsps_pkg::lamp_t             lamps;

  // phases in use, clamped to 1..MaxPhases
  always_comb begin
    used = cfg.phase_count;
    if (cfg.phase_count == '0) begin
      used = tsps_pkg::CountW'(1);
    end else if (cfg.phase_count > tsps_pkg::CountW'(tsps_pkg::MaxPhases)) begin
      used = tsps_pkg::CountW'(tsps_pkg::MaxPhases);
    end
    last_idx = tsps_pkg::IdxW'(used - tsps_pkg::CountW'(1));
  end

  assign dur      = cfg.phase_word[idx][tsps_pkg::DurW-1:0];
  assign seq_mode = (cfg.override_mode == tsps_pkg::ModeSequence) ||
                    (cfg.override_mode == tsps_pkg::ModeSeqAlias);

  // shared add/subtract unit; carry out is overflow on add, "a >= b" on subtract
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state)
      tsps_pkg::ST_SUM: begin
        op_a = tsps_pkg::PosW'(cycle_len);
        op_b = tsps_pkg::PosW'(dur);
      end
      tsps_pkg::ST_WALK: begin
        op_a   = tsps_pkg::PosW'(thres);
        op_b   = tsps_pkg::PosW'(dur);
        op_sub = 1'b1;
      end
      tsps_pkg::ST_ADV: begin
        op_a = pos;
        op_b = tsps_pkg::PosW'(elapsed);
      end
      tsps_pkg::ST_WRAP: begin
        op_a   = pos;
        op_b   = tsps_pkg::PosW'(cycle_len);
        op_sub = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign alu       = {1'b0, op_a} + {1'b0, op_b ^ {tsps_pkg::PosW{op_sub}}}
                   + (tsps_pkg::PosW+1)'(op_sub);
  assign alu_val   = alu[tsps_pkg::PosW-1:0];
  assign alu_carry = alu[tsps_pkg::PosW];

  // walking down: the first phase whose start the position has reached
  assign walk_hit = (pos >= alu_val) || (idx == '0);

  // lamp decode from the chosen phase or the forced color
  always_comb begin
    sel_word = cfg.phase_word[phase];
    mode_m1  = cfg.override_mode - tsps_pkg::ModeW'(1);
    if (seq_mode) begin
      color = sel_word[tsps_pkg::ColorLsb +: tsps_pkg::ColorW];
      if (color == tsps_pkg::ColorRedAlso) begin
        color = tsps_pkg::ColorRed;
      end
      flash = sel_word[tsps_pkg::FlashBit];
    end else begin
      color = mode_m1[2:1];
      flash = mode_m1[0];
    end
    dark               = flash && pos[3];
    lamps.red_on       = !dark && (color == tsps_pkg::ColorRed);
    lamps.yellow_on    = !dark && (color == tsps_pkg::ColorYellow);
    lamps.green_on     = !dark && (color == tsps_pkg::ColorGreen);
    lamps.active_phase = seq_mode ? phase : '0;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tsps_pkg::ST_IDLE: begin
        if (start) state_next = tsps_pkg::ST_SUM;
      end
      tsps_pkg::ST_SUM: begin
        if (idx == last_idx) state_next = seq_mode ? tsps_pkg::ST_WALK : tsps_pkg::ST_ADV;
      end
      tsps_pkg::ST_WALK: begin
        if (walk_hit) state_next = tsps_pkg::ST_ADV;
      end
      tsps_pkg::ST_ADV: begin
        state_next = first ? tsps_pkg::ST_DONE : tsps_pkg::ST_WRAP;
      end
      tsps_pkg::ST_WRAP: begin
        state_next = tsps_pkg::ST_DONE;
      end
      tsps_pkg::ST_DONE: begin
        if (take) state_next = tsps_pkg::ST_IDLE;
      end
      default: begin
        state_next = tsps_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle = (state == tsps_pkg::ST_IDLE);
  assign done = (state == tsps_pkg::ST_DONE);

  // cycle position
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pos <= '0;
    end else if (state == tsps_pkg::ST_ADV && !first) begin
      pos <= alu_carry ? tsps_pkg::PosMax : alu_val;
    end else if (state == tsps_pkg::ST_WRAP && alu_carry) begin
      pos <= alu_val;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      tsps_pkg::ST_IDLE: begin
        if (start) begin
          elapsed   <= evt.elapsed_ticks;
          first     <= evt.first_event;
          cycle_len <= '0;
          idx       <= '0;
        end
      end
      tsps_pkg::ST_SUM: begin
        cycle_len <= alu_val[tsps_pkg::CycW-1:0];
        if (idx == last_idx) begin
          thres <= alu_val[tsps_pkg::CycW-1:0];
          phase <= '0;
        end else begin
          idx <= idx + tsps_pkg::IdxW'(1);
        end
      end
      tsps_pkg::ST_WALK: begin
        if (walk_hit) begin
          phase <= idx;
        end else begin
          thres <= alu_val[tsps_pkg::CycW-1:0];
          idx   <= idx - tsps_pkg::IdxW'(1);
        end
      end
      tsps_pkg::ST_ADV: begin
        result <= lamps;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/timed_signal_phase_sequencer.sv */
// From event accept to lamp_valid the core sums the cycle length over the phases in
// use (one phase per cycle), walks back to the active phase (sequence mode only),
// captures the lamps, then advances and wraps the position unless the event is first.
// A new event is accepted only after the last result is taken; the single shared adder
// sets the pace. Reset: synchronous, active high; config registers take their documented
// defaults and the cycle position clears to zero, as on any config write to index 0..5.
module timed_signal_phase_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          evt_valid,
  output logic                          evt_ready,
  input  tsps_pkg::evt_t                evt,
  output logic                          lamp_valid,
  input  logic                          lamp_ready,
  output tsps_pkg::lamp_t               lamp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tsps_pkg::WordW-1:0]    cfg_data
);

  tsps_pkg::cfg_t  cfg;
  tsps_pkg::lamp_t result;
  logic            cfg_we;
  logic            clear;
  logic            start;
  logic            idle;
  logic            done;
  logic            take;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign clear     = cfg_we && (cfg_index <= tsps_pkg::RegWord3);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.override_mode <= tsps_pkg::ModeReset;
      cfg.phase_count   <= tsps_pkg::CountReset;
      cfg.phase_word[0] <= tsps_pkg::Word0Reset;
      cfg.phase_word[1] <= tsps_pkg::Word1Reset;
      cfg.phase_word[2] <= tsps_pkg::Word2Reset;
      cfg.phase_word[3] <= tsps_pkg::Word3Reset;
    end else if (cfg_we) begin
      case (cfg_index)
        tsps_pkg::RegMode:  cfg.override_mode <= cfg_data[tsps_pkg::ModeW-1:0];
        tsps_pkg::RegCount: cfg.phase_count   <= cfg_data[tsps_pkg::CountW-1:0];
        tsps_pkg::RegWord0: cfg.phase_word[0] <= cfg_data;
        tsps_pkg::RegWord1: cfg.phase_word[1] <= cfg_data;
        tsps_pkg::RegWord2: cfg.phase_word[2] <= cfg_data;
        tsps_pkg::RegWord3: cfg.phase_word[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign evt_ready = idle;
  assign start     = evt_valid && evt_ready;
  assign take      = done && (!lamp_valid || lamp_ready);

  tsps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .clear  (clear),
    .start  (start),
    .evt    (evt),
    .take   (take),
    .idle   (idle),
    .done   (done),
    .result (result)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_valid <= 1'b0;
    end else if (take) begin
      lamp_valid <= 1'b1;
    end else if (lamp_ready) begin
      lamp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lamp <= result;
    end
  end

endmodule

/* bench/tb_timed_signal_phase_sequencer.sv */
// Tracks the sequencer state and the lamp beats still owed by the block
class lamp_scoreboard;
  logic [tsps_pkg::ModeW-1:0]  mode;
  logic [tsps_pkg::CountW-1:0] count;
  logic [tsps_pkg::WordW-1:0]  word [tsps_pkg::MaxPhases];
  logic [tsps_pkg::PosW-1:0]   pos;
  tsps_pkg::lamp_t             lamp_due [$];
  int                          errors;

  function new();
    mode    = tsps_pkg::ModeReset;
    count   = tsps_pkg::CountReset;
    word[0] = tsps_pkg::Word0Reset;
    word[1] = tsps_pkg::Word1Reset;
    word[2] = tsps_pkg::Word2Reset;
    word[3] = tsps_pkg::Word3Reset;
    pos     = '0;
    errors  = 0;
  endfunction

  function int unsigned dur(int i);
    return word[i][tsps_pkg::DurW-1:0];
  endfunction

  // register write: any listed register clears the cycle position
  function void write_reg(logic [tsps_pkg::CfgIdxW-1:0] idx,
                          logic [tsps_pkg::WordW-1:0] data);
    case (idx)
      tsps_pkg::RegMode:  mode = data[tsps_pkg::ModeW-1:0];
      tsps_pkg::RegCount: count = data[tsps_pkg::CountW-1:0];
      tsps_pkg::RegWord0: word[0] = data;
      tsps_pkg::RegWord1: word[1] = data;
      tsps_pkg::RegWord2: word[2] = data;
      tsps_pkg::RegWord3: word[3] = data;
      default:  return;
    endcase
    pos = '0;
  endfunction

  // accepted event: work out its lamp beat, then advance the position
  function void note_event(tsps_pkg::evt_t e);
    int unsigned                 used;
    int unsigned                 cycle;
    int unsigned                 thres;
    int unsigned                 nxt;
    logic [tsps_pkg::ColorW-1:0] color;
    logic [tsps_pkg::IdxW-1:0]   phase;
    logic                        flash;
    logic                        dark;
    logic                        found;
    tsps_pkg::lamp_t             r;
    used = count;
    if (used == 0) used = 1;
    if (used > tsps_pkg::MaxPhases) used = tsps_pkg::MaxPhases;
    cycle = 0;
    for (int i = 0; i < used; i++) cycle += dur(i);
    phase = '0;
    if (mode == tsps_pkg::ModeSequence || mode == tsps_pkg::ModeSeqAlias) begin
      // walk back from the last phase in use; phase 0 always qualifies
      thres = cycle;
      found = 1'b0;
      for (int i = used - 1; i >= 0; i--) begin
        if (!found) begin
          thres -= dur(i);
          if (pos >= thres) begin
            phase = tsps_pkg::IdxW'(i);
            found = 1'b1;
          end
        end
      end
      color = word[phase][tsps_pkg::ColorLsb +: tsps_pkg::ColorW];
      if (color == tsps_pkg::ColorRedAlso) color = tsps_pkg::ColorRed;
      flash = word[phase][tsps_pkg::FlashBit];
    end else begin
      color = tsps_pkg::ColorW'((mode - 3'd1) >> 1);
      flash = ((mode - 3'd1) & 3'd1) != 3'd0;
    end
    dark = flash && pos[3];
    r.red_on       = !dark && color == tsps_pkg::ColorRed;
    r.yellow_on    = !dark && color == tsps_pkg::ColorYellow;
    r.green_on     = !dark && color == tsps_pkg::ColorGreen;
    r.active_phase = phase;
    lamp_due.insert(lamp_due.size(), r);
    if (!e.first_event) begin
      nxt = pos + e.elapsed_ticks;
      if (nxt > tsps_pkg::PosMax) nxt = tsps_pkg::PosMax;
      if (nxt >= cycle) nxt -= cycle;
      pos = nxt[tsps_pkg::PosW-1:0];
    end
  endfunction

  function void check_lamp(tsps_pkg::lamp_t got);
    tsps_pkg::lamp_t want;
    if (lamp_due.size() == 0) begin
      $error("lamp beat with no event pending: %b", got);
      errors++;
      return;
    end
    want = lamp_due.pop_front();
    if (got.red_on !== want.red_on) begin
      $error("red_on: expected %0d, got %0d", want.red_on, got.red_on);
      errors++;
    end
    if (got.yellow_on !== want.yellow_on) begin
      $error("yellow_on: expected %0d, got %0d", want.yellow_on, got.yellow_on);
      errors++;
    end
    if (got.green_on !== want.green_on) begin
      $error("green_on: expected %0d, got %0d", want.green_on, got.green_on);
      errors++;
    end
    if (got.active_phase !== want.active_phase) begin
      $error("active_phase: expected %0d, got %0d", want.active_phase, got.active_phase);
      errors++;
    end
  endfunction

  function int outstanding();
    return lamp_due.size();
  endfunction
endclass

module tb_timed_signal_phase_sequencer;

  // forced-color modes
  localparam logic [tsps_pkg::ModeW-1:0] ModeRed         = 3'd1;
  localparam logic [tsps_pkg::ModeW-1:0] ModeGreenFlash  = 3'd6;
  // indexes past the register list
  localparam logic [tsps_pkg::CfgIdxW-1:0] RegBeyondLo   = 3'd6;
  localparam logic [tsps_pkg::CfgIdxW-1:0] RegBeyondHi   = 3'd7;

  localparam int EventTarget = 1900;
  localparam int DrainCycles = 16;
  localparam int StallLimit  = 2000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           evt_valid = 1'b0;
  logic                           evt_ready;
  tsps_pkg::evt_t                 evt = '0;
  logic                           lamp_valid;
  logic                           lamp_ready = 1'b0;
  tsps_pkg::lamp_t                lamp;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tsps_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [tsps_pkg::WordW-1:0]     cfg_data = '0;

  lamp_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent_count = 0;
  int quiet_cycles = 0;

  timed_signal_phase_sequencer dut (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .evt        (evt),
    .lamp_valid (lamp_valid),
    .lamp_ready (lamp_ready),
    .lamp       (lamp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    lamp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // lamp beat check
  always @(posedge clk) begin
    if (!rst && lamp_valid && lamp_ready) sb.check_lamp(lamp);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((evt_valid && evt_ready) || (lamp_valid && lamp_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic tsps_pkg::evt_t make_event(logic [tsps_pkg::DurW-1:0] ticks,
                                                logic first);
    tsps_pkg::evt_t e;
    e.elapsed_ticks = ticks;
    e.first_event   = first;
    return e;
  endfunction

  // phase word: mostly short durations, some zero, full scale or raw
  function automatic logic [tsps_pkg::WordW-1:0] rand_word();
    logic [tsps_pkg::WordW-1:0] w;
    int unsigned                pick;
    pick = $urandom_range(9);
    w = tsps_pkg::WordW'($urandom());
    if (pick == 0) return w;
    if (pick == 1) w[tsps_pkg::DurW-1:0] = '0;
    else if (pick == 2) w[tsps_pkg::DurW-1:0] = '1;
    else if (pick != 3) w[tsps_pkg::DurW-1:0] = tsps_pkg::DurW'($urandom_range(1, 40));
    return w;
  endfunction

  function automatic logic [tsps_pkg::DurW-1:0] rand_elapsed();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return tsps_pkg::DurW'($urandom_range(0, 20));
    if (pick < 80) return tsps_pkg::DurW'($urandom_range(0, 300));
    if (pick < 84) return '1;
    if (pick < 88) return '0;
    return tsps_pkg::DurW'($urandom());
  endfunction

  // one event beat; drain holds off until every lamp beat is back
  task automatic send_event(tsps_pkg::evt_t e, bit drain = 1'b0);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (drain && gaps == 0) gaps = 1;
    if (gaps > 0) begin
      evt_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
      while (drain && sb.outstanding() != 0) @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt <= e;
    do @(posedge clk); while (!evt_ready);
    sb.note_event(e);
    sent_count++;
  endtask

  task automatic write_reg(logic [tsps_pkg::CfgIdxW-1:0] idx,
                           logic [tsps_pkg::WordW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  // wait until the block has nothing left in flight
  task automatic settle();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_setting();
    logic [tsps_pkg::WordW-1:0] data;
    int unsigned                pick;
    data = tsps_pkg::WordW'($urandom());
    if ($urandom_range(3) != 0) data[tsps_pkg::ModeW-1:0] = tsps_pkg::ModeSequence;
    write_reg(tsps_pkg::RegMode, data);
    data = tsps_pkg::WordW'($urandom());
    pick = $urandom_range(9);
    if (pick < 7) begin
      data[tsps_pkg::CountW-1:0] = tsps_pkg::CountW'($urandom_range(1, tsps_pkg::MaxPhases));
    end else if (pick == 7) begin
      data[tsps_pkg::CountW-1:0] = '0;
    end else begin
      data[tsps_pkg::CountW-1:0] =
        tsps_pkg::CountW'($urandom_range(tsps_pkg::MaxPhases + 1, 7));
    end
    write_reg(tsps_pkg::RegCount, data);
    if ($urandom_range(3) != 0) write_reg(tsps_pkg::RegWord0, rand_word());
    if ($urandom_range(3) != 0) write_reg(tsps_pkg::RegWord1, rand_word());
    if ($urandom_range(3) != 0) write_reg(tsps_pkg::RegWord2, rand_word());
    if ($urandom_range(3) != 0) write_reg(tsps_pkg::RegWord3, rand_word());
    if ($urandom_range(5) == 0) write_reg($urandom_range(1) ? RegBeyondLo : RegBeyondHi,
                                          tsps_pkg::WordW'($urandom()));
    cfg_release();
  endtask

  initial begin
    int k;
    int n;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset table: first event, walk through all phases, wrap, past the cycle
    send_event(make_event('1, 1'b1));
    send_event(make_event(16'd0, 1'b0));
    send_event(make_event(16'd40, 1'b0));
    send_event(make_event(16'd20, 1'b0));
    send_event(make_event(16'd60, 1'b0));
    send_event(make_event('1, 1'b0));
    send_event(make_event(16'd1, 1'b0));
    settle();

    // each forced color and the sequence alias, flash on bit 3
    for (int m = ModeRed; m <= tsps_pkg::ModeSeqAlias; m++) begin
      write_reg(tsps_pkg::RegMode, tsps_pkg::WordW'(m));
      cfg_release();
      send_event(make_event(16'd8, 1'b0));
      send_event(make_event(16'd0, 1'b0));
      settle();
    end

    // phase count of zero, all-ones word
    write_reg(tsps_pkg::RegMode, tsps_pkg::WordW'(tsps_pkg::ModeSequence));
    write_reg(tsps_pkg::RegCount, '0);
    write_reg(tsps_pkg::RegWord0, '1);
    cfg_release();
    send_event(make_event(16'd3, 1'b0));
    send_event(make_event('1, 1'b0));
    send_event(make_event(16'd5, 1'b0));
    settle();

    // count above the table size, writes past the register list
    write_reg(tsps_pkg::RegCount, tsps_pkg::WordW'(7));
    write_reg(tsps_pkg::RegWord3, {1'b1, tsps_pkg::ColorGreen, 16'd9});
    write_reg(RegBeyondLo, '1);
    write_reg(RegBeyondHi, tsps_pkg::WordW'($urandom()));
    cfg_release();
    send_event(make_event('1, 1'b0));
    send_event(make_event(16'd100, 1'b0));
    send_event(make_event(16'd0, 1'b0));
    settle();

    // zero cycle length: no wrap, position saturates
    write_reg(tsps_pkg::RegCount, tsps_pkg::WordW'(tsps_pkg::MaxPhases));
    write_reg(tsps_pkg::RegWord0, {1'b1, tsps_pkg::ColorYellow, 16'd0});
    write_reg(tsps_pkg::RegWord1,
              {tsps_pkg::WordW'($urandom()) & ~tsps_pkg::WordW'(16'hFFFF)});
    write_reg(tsps_pkg::RegWord2, {1'b0, tsps_pkg::ColorGreen, 16'd0});
    write_reg(tsps_pkg::RegWord3, {1'b1, tsps_pkg::ColorRedAlso, 16'd0});
    write_reg(tsps_pkg::RegMode, tsps_pkg::WordW'(ModeGreenFlash));
    write_reg(tsps_pkg::RegMode, tsps_pkg::WordW'(tsps_pkg::ModeSequence));
    cfg_release();
    repeat (20) send_event(make_event('1, 1'b0));
    send_event(make_event('1, 1'b1));
    settle();

    // random settings, rotating through the idle patterns
    k = 0;
    while (sent_count < EventTarget) begin
      random_setting();
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      n = $urandom_range(30, 90);
      for (int j = 0; j < n; j++) begin
        send_event(make_event(rand_elapsed(), $urandom_range(9) == 0),
                   (k == 2 && j == 0) || $urandom_range(99) < 2);
      end
      settle();
      k++;
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
